### rtl/r2q_pkg.sv
`default_nettype none
package r2q_pkg;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;
	localparam int PICK_BITS      = 2;

	typedef enum logic [PICK_BITS-1:0] {
		PICK_W = 2'd0,
		PICK_X = 2'd1,
		PICK_Y = 2'd2,
		PICK_Z = 2'd3
	} pick_t;
endpackage
`default_nettype wire

### rtl/r2q_front.sv
`default_nettype none
module r2q_front #(
	parameter int DW  = r2q_pkg::DATA_WIDTH_DEF,
	parameter int FB  = r2q_pkg::FRAC_BITS_DEF,
	parameter int RBW = 19,
	parameter int RTW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vld_i,
	input  wire logic signed [DW-1:0]  m00,
	input  wire logic signed [DW-1:0]  m01,
	input  wire logic signed [DW-1:0]  m02,
	input  wire logic signed [DW-1:0]  m10,
	input  wire logic signed [DW-1:0]  m11,
	input  wire logic signed [DW-1:0]  m12,
	input  wire logic signed [DW-1:0]  m20,
	input  wire logic signed [DW-1:0]  m21,
	input  wire logic signed [DW-1:0]  m22,
	output logic                       vld_s1,
	output r2q_pkg::pick_t             pick_s1,
	output logic                       deg_s1,
	output logic [3:0][DW:0]           d_s1,
	output logic [2*RTW-1:0]           rad_s1
);
	localparam logic signed [RBW-1:0] ONE = RBW'(64'd1 << FB);

	logic signed [DW+1:0]  tr;
	logic signed [RBW-1:0] e00, e11, e22, r;
	logic signed [DW:0]    x01, x02, x10, x12, x20, x21;
	r2q_pkg::pick_t        pick;
	logic [3:0][DW:0]      d;
	logic                  deg;

	always_comb begin
		tr  = (DW+2)'(m00) + (DW+2)'(m11) + (DW+2)'(m22);
		e00 = RBW'(m00);
		e11 = RBW'(m11);
		e22 = RBW'(m22);
		x01 = (DW+1)'(m01);
		x02 = (DW+1)'(m02);
		x10 = (DW+1)'(m10);
		x12 = (DW+1)'(m12);
		x20 = (DW+1)'(m20);
		x21 = (DW+1)'(m21);
		d   = '0;
		if (tr > 0) begin
			pick = r2q_pkg::PICK_W;
			r    = ONE + RBW'(tr);
			d[1] = x21 - x12;
			d[2] = x02 - x20;
			d[3] = x10 - x01;
		end else if (m00 > m11 && m00 > m22) begin
			pick = r2q_pkg::PICK_X;
			r    = ONE + e00 - e11 - e22;
			d[0] = x21 - x12;
			d[2] = x01 + x10;
			d[3] = x02 + x20;
		end else if (m11 > m22) begin
			pick = r2q_pkg::PICK_Y;
			r    = ONE + e11 - e00 - e22;
			d[0] = x02 - x20;
			d[1] = x01 + x10;
			d[3] = x12 + x21;
		end else begin
			pick = r2q_pkg::PICK_Z;
			r    = ONE + e22 - e00 - e11;
			d[0] = x10 - x01;
			d[1] = x02 + x20;
			d[2] = x12 + x21;
		end
		deg = (r <= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pick_s1 <= pick;
			deg_s1  <= deg;
			d_s1    <= d;
			rad_s1  <= deg ? '0 : (((2*RTW)'($unsigned(r))) << FB);
		end
	end
endmodule
`default_nettype wire

### rtl/r2q_sqrt_cell.sv
`default_nettype none
module r2q_sqrt_cell #(
	parameter int RTW = 16,
	parameter int PLW = 71
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_i,
	input  wire logic [RTW:0]     rem_i,
	input  wire logic [RTW-1:0]   root_i,
	input  wire logic [2*RTW-1:0] rad_i,
	input  wire logic [PLW-1:0]   pl_i,
	output logic                  vld_s1,
	output logic [RTW:0]          rem_s1,
	output logic [RTW-1:0]        root_s1,
	output logic [2*RTW-1:0]      rad_s1,
	output logic [PLW-1:0]        pl_s1
);
	logic [RTW+2:0] cur, trial, diff;
	logic           ge;

	always_comb begin
		cur   = {rem_i, rad_i[2*RTW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= ge ? diff[RTW:0] : cur[RTW:0];
			root_s1 <= {root_i[RTW-2:0], ge};
			rad_s1  <= {rad_i[2*RTW-3:0], 2'b00};
			pl_s1   <= pl_i;
		end
	end
endmodule
`default_nettype wire

### rtl/r2q_div_cell.sv
`default_nettype none
module r2q_div_cell #(
	parameter int NW  = 32,
	parameter int DVW = 17,
	parameter int PLW = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vld_i,
	input  wire logic [3:0][DVW-1:0]  rem_i,
	input  wire logic [3:0][NW-1:0]   nq_i,
	input  wire logic [DVW-1:0]       dvs_i,
	input  wire logic [PLW-1:0]       pl_i,
	output logic                      vld_s1,
	output logic [3:0][DVW-1:0]       rem_s1,
	output logic [3:0][NW-1:0]        nq_s1,
	output logic [DVW-1:0]            dvs_s1,
	output logic [PLW-1:0]            pl_s1
);
	logic [3:0][DVW-1:0] rem_n;
	logic [3:0][NW-1:0]  nq_n;
	logic [DVW:0]        t, sub;
	logic                ge;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			t        = {rem_i[i], nq_i[i][NW-1]};
			sub      = t - {1'b0, dvs_i};
			ge       = (t >= {1'b0, dvs_i});
			rem_n[i] = ge ? sub[DVW-1:0] : t[DVW-1:0];
			nq_n[i]  = {nq_i[i][NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_n;
			nq_s1  <= nq_n;
			dvs_s1 <= dvs_i;
			pl_s1  <= pl_i;
		end
	end
endmodule
`default_nettype wire

### rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, trace method, signed fixed point.
// Input channel: mat_valid / mat_stall with the nine entries m00..m22 as one
// word. Output channel: quat_valid / quat_stall with qw, qx, qy, qz and the
// degenerate flag as one word. A word moves on a clock edge where valid is
// high and stall is low.
// Throughput: one word per cycle while quat_stall is low. The pipeline holds
// a front register, one square-root cell per bit of the RTW-bit root, a
// register, one divider cell per quotient bit of the NW-bit numerator and
// an output register. The default is the 16-bit, 14-fraction-bit format.
// All stages advance together; when the output word is valid and the
// receiver stalls, the whole pipeline holds and mat_stall is raised in the
// same cycle. Words already inside are kept, none is dropped.
// Reset clears every valid bit, so the block is empty and ready at once after
// arst_n rises; there is no clearing pass.
`default_nettype none
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = r2q_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = r2q_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         mat_valid,
	output logic                              mat_stall,
	input  wire logic signed [DATA_WIDTH-1:0] m00,
	input  wire logic signed [DATA_WIDTH-1:0] m01,
	input  wire logic signed [DATA_WIDTH-1:0] m02,
	input  wire logic signed [DATA_WIDTH-1:0] m10,
	input  wire logic signed [DATA_WIDTH-1:0] m11,
	input  wire logic signed [DATA_WIDTH-1:0] m12,
	input  wire logic signed [DATA_WIDTH-1:0] m20,
	input  wire logic signed [DATA_WIDTH-1:0] m21,
	input  wire logic signed [DATA_WIDTH-1:0] m22,
	output logic                              quat_valid,
	input  wire logic                         quat_stall,
	output logic signed [DATA_WIDTH-1:0]      qw,
	output logic signed [DATA_WIDTH-1:0]      qx,
	output logic signed [DATA_WIDTH-1:0]      qy,
	output logic signed [DATA_WIDTH-1:0]      qz,
	output logic                              degenerate
);
	localparam int DW  = DATA_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int RBW = ((FB > DW) ? FB : DW + 1) + 2;
	localparam int RTW = (RBW + FB + 1) / 2;
	localparam int NW  = DW + FB + 2;
	localparam int DVW = RTW + 1;
	localparam int SPL = r2q_pkg::PICK_BITS + 1 + 4 * (DW + 1);
	localparam int DPL = r2q_pkg::PICK_BITS + 1 + 4;
	localparam logic [NW-1:0] MAXP_N = NW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic [NW-1:0] MINM_N = NW'(64'd1 << (DW - 1));
	localparam logic [DW-1:0] MAXP_D = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_D  = {1'b1, {(DW-1){1'b0}}};

	function automatic logic [DW-1:0] sat_fn(input logic neg, input logic [NW-1:0] mag);
		logic [NW-1:0] ng;
		ng = NW'(0) - mag;
		if (!neg) begin
			return (mag > MAXP_N) ? MAXP_D : mag[DW-1:0];
		end
		return (mag > MINM_N) ? MIN_D : ng[DW-1:0];
	endfunction

	logic en;
	assign en        = !quat_valid || !quat_stall;
	assign mat_stall = !en;

	logic             fr_vld, fr_deg;
	r2q_pkg::pick_t   fr_pick;
	logic [3:0][DW:0] fr_d;
	logic [2*RTW-1:0] fr_rad;

	r2q_front #(.DW(DW), .FB(FB), .RBW(RBW), .RTW(RTW)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(mat_valid),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.vld_s1(fr_vld), .pick_s1(fr_pick), .deg_s1(fr_deg),
		.d_s1(fr_d), .rad_s1(fr_rad)
	);

	logic             sq_vld  [0:RTW];
	logic [RTW:0]     sq_rem  [0:RTW];
	logic [RTW-1:0]   sq_root [0:RTW];
	logic [2*RTW-1:0] sq_rad  [0:RTW];
	logic [SPL-1:0]   sq_pl   [0:RTW];

	assign sq_vld[0]  = fr_vld;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = fr_rad;
	assign sq_pl[0]   = {fr_pick, fr_deg, fr_d};

	for (genvar k = 0; k < RTW; k++) begin : g_sqrt
		r2q_sqrt_cell #(.RTW(RTW), .PLW(SPL)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(sq_vld[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
			.rad_i(sq_rad[k]), .pl_i(sq_pl[k]),
			.vld_s1(sq_vld[k+1]), .rem_s1(sq_rem[k+1]), .root_s1(sq_root[k+1]),
			.rad_s1(sq_rad[k+1]), .pl_s1(sq_pl[k+1])
		);
	end

	logic [3:0][DW:0]  sq_d;
	logic              sq_deg;
	r2q_pkg::pick_t    sq_pick;
	logic [3:0]        neg;
	logic [3:0][NW-1:0] num;
	logic [DW:0]       mag;

	always_comb begin
		sq_d    = sq_pl[RTW][4*(DW+1)-1:0];
		sq_deg  = sq_pl[RTW][4*(DW+1)];
		sq_pick = r2q_pkg::pick_t'(sq_pl[RTW][SPL-1 -: r2q_pkg::PICK_BITS]);
		for (int i = 0; i < 4; i++) begin
			neg[i] = sq_d[i][DW];
			mag    = neg[i] ? (~sq_d[i] + 1'b1) : sq_d[i];
			num[i] = (NW'(mag) << FB) + NW'(sq_root[RTW]);
		end
	end

	logic               vld_s2;
	logic [3:0][NW-1:0] num_s2;
	logic [DVW-1:0]     dvs_s2;
	logic [DPL-1:0]     pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= sq_vld[RTW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num;
			dvs_s2 <= {sq_root[RTW], 1'b0};
			pl_s2  <= {sq_pick, sq_deg, neg};
		end
	end

	logic                dv_vld [0:NW];
	logic [3:0][DVW-1:0] dv_rem [0:NW];
	logic [3:0][NW-1:0]  dv_nq  [0:NW];
	logic [DVW-1:0]      dv_dvs [0:NW];
	logic [DPL-1:0]      dv_pl  [0:NW];

	assign dv_vld[0] = vld_s2;
	assign dv_rem[0] = '0;
	assign dv_nq[0]  = num_s2;
	assign dv_dvs[0] = dvs_s2;
	assign dv_pl[0]  = pl_s2;

	for (genvar k = 0; k < NW; k++) begin : g_div
		r2q_div_cell #(.NW(NW), .DVW(DVW), .PLW(DPL)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(dv_vld[k]), .rem_i(dv_rem[k]), .nq_i(dv_nq[k]),
			.dvs_i(dv_dvs[k]), .pl_i(dv_pl[k]),
			.vld_s1(dv_vld[k+1]), .rem_s1(dv_rem[k+1]), .nq_s1(dv_nq[k+1]),
			.dvs_s1(dv_dvs[k+1]), .pl_s1(dv_pl[k+1])
		);
	end

	r2q_pkg::pick_t     dv_pick;
	logic               dv_deg;
	logic [3:0]         dv_neg;
	logic [RTW:0]       half;
	logic [3:0][DW-1:0] qv;

	always_comb begin
		dv_pick = r2q_pkg::pick_t'(dv_pl[NW][DPL-1 -: r2q_pkg::PICK_BITS]);
		dv_deg  = dv_pl[NW][4];
		dv_neg  = dv_pl[NW][3:0];
		half    = ((RTW+1)'(dv_dvs[NW][DVW-1:1]) + 1'b1) >> 1;
		for (int i = 0; i < 4; i++) begin
			if (dv_deg) begin
				qv[i] = '0;
			end else if (dv_pick == r2q_pkg::pick_t'(2'(i))) begin
				qv[i] = sat_fn(1'b0, NW'(half));
			end else begin
				qv[i] = sat_fn(dv_neg[i], dv_nq[NW][i]);
			end
		end
	end

	logic               vld_s3, deg_s3;
	logic [3:0][DW-1:0] q_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3   <= qv;
			deg_s3 <= dv_deg;
		end
	end

	assign quat_valid = vld_s3;
	assign degenerate = deg_s3;
	assign qw         = q_s3[0];
	assign qx         = q_s3[1];
	assign qy         = q_s3[2];
	assign qz         = q_s3[3];

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quat_valid && degenerate |-> qw == 0 && qx == 0 && qy == 0 && qz == 0)
		else $error("degenerate word with nonzero components");

	a_root_live: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[RTW] && !sq_deg |-> sq_root[RTW] != 0)
		else $error("zero root on a valid radicand");

	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[RTW] |-> sq_rad[RTW] == 0 && sq_rem[RTW] <= {sq_root[RTW], 1'b0})
		else $error("square root remainder out of range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[NW] && !dv_deg |-> dv_rem[NW][0] < dv_dvs[NW] && dv_rem[NW][1] < dv_dvs[NW]
			&& dv_rem[NW][2] < dv_dvs[NW] && dv_rem[NW][3] < dv_dvs[NW])
		else $error("divider remainder not below divisor");
endmodule
`default_nettype wire
